@@ sv/rse_pkg.sv @@
`default_nettype none

package rse_pkg;

  // Width of every stored time statistic, in microseconds.
  localparam int TIME_BITS = 32;

  // Operation codes carried on the op field.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_EXPIRE  = 2'd1;
  localparam logic [1:0] OP_MIGRATE = 2'd2;

  typedef logic [TIME_BITS-1:0] time_t;

  // The full set of round-trip statistics held by the estimator.
  typedef struct packed {
    time_t latest;
    time_t minimum;
    time_t smoothed;
    time_t prior_smoothed;
    time_t deviation;
  } stats_t;

endpackage

`default_nettype wire

@@ sv/rse_update.sv @@
`default_nettype none

module rse_update (
  input  wire logic [1:0]     op,
  input  wire rse_pkg::time_t sample,
  input  wire logic           sample_is_infinite,
  input  wire rse_pkg::stats_t cur,
  output rse_pkg::stats_t     nxt,
  output logic                sample_accepted
);
  import rse_pkg::*;

  localparam int DW = TIME_BITS + 2;
  localparam int SW = TIME_BITS + 3;

  time_t           err_sample;
  time_t           err_latest;
  logic [DW-1:0]   dev_sum;
  logic [SW-1:0]   smooth_sum;
  time_t           dev_mixed;
  time_t           smooth_mixed;

  // Distance of the smoothed value from the new sample and from the latest sample.
  assign err_sample = (cur.smoothed >= sample) ? (cur.smoothed - sample)
                                               : (sample - cur.smoothed);
  assign err_latest = (cur.smoothed >= cur.latest) ? (cur.smoothed - cur.latest)
                                                   : (cur.latest - cur.smoothed);

  // Weighted averages with weights 1/4 and 1/8, kept wide so nothing overflows.
  assign dev_sum      = (DW'(cur.deviation) << 1) + DW'(cur.deviation) + DW'(err_sample);
  assign dev_mixed    = TIME_BITS'(dev_sum >> 2);
  assign smooth_sum   = (SW'(cur.smoothed) << 3) - SW'(cur.smoothed) + SW'(sample)
                        + SW'(4);
  assign smooth_mixed = TIME_BITS'(smooth_sum >> 3);

  assign sample_accepted = (op == OP_SAMPLE) && !sample_is_infinite && (sample != '0);

  // Next statistics for each operation.
  always_comb begin
    nxt = cur;
    case (op)
      OP_SAMPLE: begin
        if (sample_accepted) begin
          if ((cur.minimum == '0) || (cur.minimum > sample)) begin
            nxt.minimum = sample;
          end
          nxt.prior_smoothed = cur.smoothed;
          nxt.latest         = sample;
          if (cur.smoothed == '0) begin
            nxt.smoothed  = sample;
            nxt.deviation = sample >> 1;
          end else begin
            nxt.smoothed  = smooth_mixed;
            nxt.deviation = dev_mixed;
          end
        end
      end
      OP_EXPIRE: begin
        if (err_latest > cur.deviation) begin
          nxt.deviation = err_latest;
        end
        if (cur.latest > cur.smoothed) begin
          nxt.smoothed = cur.latest;
        end
      end
      OP_MIGRATE: begin
        nxt.latest    = '0;
        nxt.minimum   = '0;
        nxt.smoothed  = '0;
        nxt.deviation = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/rtt_smoothing_estimator.sv @@
// Channel   Handshake                    Payload
// in        in_valid / in_stall          op, sample_us, sample_is_infinite
// out       out_valid / out_stall        sample_accepted, smoothed_rtt_us,
//                                        mean_deviation_us, min_rtt_us,
//                                        latest_rtt_us, previous_smoothed_us
//
// One transaction in, one transaction out; a new transaction is taken every cycle
// unless the output stalls. Each passes an input register, then the statistics
// update into the result register; the stored-statistics update sets the rate.
// Reset (rst, synchronous) clears all statistics and both valid flags.
// While out_stall holds, the input register still takes one more transaction.
`default_nettype none

module rtt_smoothing_estimator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] sample_us,
  input  wire logic        sample_is_infinite,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             sample_accepted,
  output logic [31:0]      smoothed_rtt_us,
  output logic [31:0]      mean_deviation_us,
  output logic [31:0]      min_rtt_us,
  output logic [31:0]      latest_rtt_us,
  output logic [31:0]      previous_smoothed_us
);
  import rse_pkg::*;

  logic       s1_valid;
  logic [1:0] op_q;
  time_t      sample_q;
  logic       infinite_q;
  stats_t     stats;
  stats_t     stats_next;
  logic       accepted_next;
  logic       advance;
  logic       in_fire;

  // The result register can load when it is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q       <= op;
      sample_q   <= TIME_BITS'(sample_us);
      infinite_q <= sample_is_infinite;
    end
  end

  rse_update u_update (
    .op                 (op_q),
    .sample             (sample_q),
    .sample_is_infinite (infinite_q),
    .cur                (stats),
    .nxt                (stats_next),
    .sample_accepted    (accepted_next)
  );

  // Stored statistics advance once per transaction moved into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        stats <= stats_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      sample_accepted      <= accepted_next;
      smoothed_rtt_us      <= 32'(stats_next.smoothed);
      mean_deviation_us    <= 32'(stats_next.deviation);
      min_rtt_us           <= 32'(stats_next.minimum);
      latest_rtt_us        <= 32'(stats_next.latest);
      previous_smoothed_us <= 32'(stats_next.prior_smoothed);
    end
  end

  // The input side only stalls while it already holds a transaction.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall raised with an empty input register");

  // A result can only appear from a transaction held in the input register.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without an input transaction");

  // The minimum and the latest sample are both set or both cleared.
  a_min_latest_pair: assert property (@(posedge clk) disable iff (rst)
    (stats.minimum == '0) == (stats.latest == '0))
    else $error("minimum and latest RTT disagree on presence of a sample");

  // The smoothed value is zero exactly when no sample is held.
  a_smoothed_latest_pair: assert property (@(posedge clk) disable iff (rst)
    (stats.smoothed == '0) == (stats.latest == '0))
    else $error("smoothed RTT and latest RTT disagree on presence of a sample");

  // An applied sample leaves a nonzero minimum no larger than the latest sample.
  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && accepted_next) |=>
      (stats.minimum != '0) && (stats.minimum <= stats.latest))
    else $error("minimum RTT out of range after an applied sample");

endmodule

`default_nettype wire

@@ verif/rtt_smoothing_estimator_tb.sv @@
`timescale 1ns / 100ps

module rtt_smoothing_estimator_tb;
  import rse_pkg::*;

  // The op code that the estimator must treat as a no-op.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] sample;
    logic        infinite;
  } rtt_item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] smoothed;
    logic [31:0] deviation;
    logic [31:0] minimum;
    logic [31:0] latest;
    logic [31:0] prior;
  } rtt_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_SAMPLE;
  logic [31:0] sample_us = '0;
  logic        sample_is_infinite = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        sample_accepted;
  logic [31:0] smoothed_rtt_us;
  logic [31:0] mean_deviation_us;
  logic [31:0] min_rtt_us;
  logic [31:0] latest_rtt_us;
  logic [31:0] previous_smoothed_us;

  rtt_item_t   pending_q[$];
  rtt_report_t rtt_reports_q[$];

  // Statistics as the estimator should hold them after every accepted transaction.
  stats_t est = '0;

  int items_total = 0;
  int items_in = 0;
  int reports_checked = 0;
  int samples_taken = 0;
  int expires_seen = 0;
  int migrations_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int seg_left = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int holds_done = 0;

  rtt_smoothing_estimator u_top (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .op                   (op),
    .sample_us            (sample_us),
    .sample_is_infinite   (sample_is_infinite),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .sample_accepted      (sample_accepted),
    .smoothed_rtt_us      (smoothed_rtt_us),
    .mean_deviation_us    (mean_deviation_us),
    .min_rtt_us           (min_rtt_us),
    .latest_rtt_us        (latest_rtt_us),
    .previous_smoothed_us (previous_smoothed_us)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Update the expected statistics for one transaction and queue the report.
  function automatic void predict_rtt_update(logic [1:0] code, logic [31:0] smp, logic inf);
    rtt_report_t rep;
    logic [35:0] mix;
    logic [31:0] gap;
    rep.accepted = 1'b0;
    case (code)
      OP_SAMPLE: begin
        if (!inf && smp != 32'd0) begin
          rep.accepted = 1'b1;
          samples_taken++;
          if (est.minimum == 32'd0 || est.minimum > smp) est.minimum = smp;
          est.prior_smoothed = est.smoothed;
          est.latest = smp;
          if (est.smoothed == 32'd0) begin
            est.smoothed = smp;
            est.deviation = smp >> 1;
          end else begin
            gap = (est.smoothed >= smp) ? est.smoothed - smp : smp - est.smoothed;
            mix = {4'd0, est.deviation} * 3 + {4'd0, gap};
            est.deviation = mix[33:2];
            mix = {4'd0, est.smoothed} * 7 + {4'd0, smp} + 36'd4;
            est.smoothed = mix[34:3];
          end
        end
      end
      OP_EXPIRE: begin
        expires_seen++;
        gap = (est.smoothed >= est.latest) ? est.smoothed - est.latest
                                           : est.latest - est.smoothed;
        if (gap > est.deviation) est.deviation = gap;
        if (est.latest > est.smoothed) est.smoothed = est.latest;
      end
      OP_MIGRATE: begin
        migrations_seen++;
        est.latest = '0;
        est.minimum = '0;
        est.smoothed = '0;
        est.deviation = '0;
      end
      default: ;
    endcase
    rep.smoothed = est.smoothed;
    rep.deviation = est.deviation;
    rep.minimum = est.minimum;
    rep.latest = est.latest;
    rep.prior = est.prior_smoothed;
    rtt_reports_q.push_back(rep);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  function automatic void add_item(logic [1:0] code, logic [31:0] smp, logic inf);
    rtt_item_t it;
    it.code = code;
    it.sample = smp;
    it.infinite = inf;
    pending_q.push_back(it);
  endfunction

  // Sample value for a session whose typical RTT is base.
  function automatic logic [31:0] pick_sample(logic [31:0] base);
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return $urandom_range(1, 15);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return base - (base >> 2) + $urandom_range(0, base >> 1);
    endcase
  endfunction

  // Directed transactions, then sessions of mostly valid samples with some noise.
  function automatic void build_stimulus();
    int useful;
    int sess_len;
    int pick;
    logic [31:0] base;
    add_item(OP_EXPIRE, 32'd0, 1'b0);
    add_item(OP_SAMPLE, 32'd0, 1'b0);
    add_item(OP_SAMPLE, 32'd5000, 1'b1);
    add_item(OP_SAMPLE, 32'd1000, 1'b0);
    add_item(OP_SAMPLE, 32'd1200, 1'b0);
    add_item(OP_SAMPLE, 32'd800, 1'b0);
    add_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_SAMPLE, 32'd1, 1'b0);
    add_item(OP_EXPIRE, 32'hFFFF_FFFF, 1'b1);
    add_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_EXPIRE, 32'd0, 1'b0);
    add_item(OP_RESERVED, 32'hA5A5_5A5A, 1'b1);
    add_item(OP_MIGRATE, 32'h1234_5678, 1'b0);
    add_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1);
    add_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_EXPIRE, 32'd0, 1'b0);
    add_item(OP_MIGRATE, 32'd0, 1'b0);
    add_item(OP_MIGRATE, 32'd0, 1'b1);
    add_item(OP_SAMPLE, 32'd7, 1'b0);
    add_item(OP_SAMPLE, 32'd3, 1'b0);
    add_item(OP_EXPIRE, 32'd0, 1'b0);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: base = $urandom_range(1, 64);
        1: base = $urandom_range(100, 2_000_000);
        2: base = $urandom_range(32'h1000_0000, 32'hC000_0000);
        default: base = $urandom_range(2_000, 300_000);
      endcase
      sess_len = $urandom_range(5, 60);
      for (int i = 0; i < sess_len && useful < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        useful++;
        if (pick < 75) begin
          add_item(OP_SAMPLE, pick_sample(base), 1'b0);
        end else if (pick < 85) begin
          add_item(OP_EXPIRE, $urandom, 1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
          add_item(OP_SAMPLE, $urandom, 1'b1);
        end else if (pick < 94) begin
          add_item(OP_SAMPLE, 32'd0, 1'b0);
        end else if (pick < 97) begin
          add_item(OP_RESERVED, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          add_item(OP_MIGRATE, $urandom, 1'($urandom_range(0, 1)));
        end
      end
      // Most sessions end with a connection migration.
      if ($urandom_range(0, 2) != 0) begin
        add_item(OP_MIGRATE, $urandom, 1'($urandom_range(0, 1)));
        useful++;
      end
    end
  endfunction

  // Sender: offers queued transactions in bursts with random gaps.
  always @(posedge clk) begin : drive_proc
    rtt_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rtt_update(op, sample_us, sample_is_infinite);
        items_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          in_valid <= 1'b1;
          op <= nxt.code;
          sample_us <= nxt.sample;
          sample_is_infinite <= nxt.infinite;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stalls in segments of varying density, with two long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && items_in >= 120 * (holds_done + 1)) begin
      holds_done++;
      hold_left = 80;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        seg_left--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: compares each result transaction with the oldest expected report.
  always @(posedge clk) begin : check_proc
    rtt_report_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (rtt_reports_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result transaction with no report expected", $realtime);
        mismatches++;
      end else begin
        want = rtt_reports_q.pop_front();
        reports_checked++;
        check_field("sample_accepted", {31'd0, want.accepted}, {31'd0, sample_accepted});
        check_field("smoothed_rtt_us", want.smoothed, smoothed_rtt_us);
        check_field("mean_deviation_us", want.deviation, mean_deviation_us);
        check_field("min_rtt_us", want.minimum, min_rtt_us);
        check_field("latest_rtt_us", want.latest, latest_rtt_us);
        check_field("previous_smoothed_us", want.prior, previous_smoothed_us);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $realtime, rtt_reports_q.size());
      $display("rtt_smoothing_estimator_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_stimulus();
    items_total = pending_q.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Every queued transaction must come back as a checked result.
    while (reports_checked < items_total) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d transactions: %0d samples taken, %0d expires, %0d migrations.",
             items_in, samples_taken, expires_seen, migrations_seen);
    $display("Checked %0d result transactions, %0d field mismatches, %0d long hold-offs.",
             reports_checked, mismatches, holds_done);
    if (mismatches == 0) begin
      $display("rtt_smoothing_estimator_tb: clean");
    end else begin
      $display("rtt_smoothing_estimator_tb: errors");
    end
    $finish;
  end

endmodule
